/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL. All checks sample on the rising clock
// edge and are held off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* rtl/core/bmpa_pkg.sv */
`default_nettype none

package bmpa_pkg;

	// Default sizes of the message store.
	localparam int DEF_MAX_MESSAGES = 8;
	localparam int DEF_MSG_BYTES    = 3;

	// Fixed field widths.
	localparam int CNT_W   = 4;
	localparam int LEN_W   = 2;
	localparam int TIME_W  = 13;
	localparam int TLOW_W  = 7;
	localparam int THIGH_W = TIME_W - TLOW_W;
	localparam int BYTE_W  = 8;
	localparam int FIELD_BYTES = 3;

	// Command queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// Input action codes.
	localparam logic [1:0] ACT_POST  = 2'd0;
	localparam logic [1:0] ACT_EMIT  = 2'd1;
	localparam logic [1:0] ACT_FLUSH = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_PACKET  = 2'd0;
	localparam logic [1:0] ST_POSTED  = 2'd1;
	localparam logic [1:0] ST_DROPPED = 2'd2;
	localparam logic [1:0] ST_FLUSHED = 2'd3;

	typedef enum logic [1:0] {
		CMD_POST,
		CMD_EMIT,
		CMD_FLUSH
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                          kind;
		logic [LEN_W-1:0]                   len;
		logic [FIELD_BYTES-1:0][BYTE_W-1:0] msg_bytes;
		logic [TIME_W-1:0]                  post_time;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef enum logic {
		BK_IDLE,
		BK_EMIT
	} bk_state_t;

endpackage

`default_nettype wire

/* rtl/core/ble_midi_packet_assembler.sv */
// Channel  Direction  Ports                      Content
// s        in         s_tvalid/tready/tdata/tuser action, message and post time
// m        out        m_tvalid/tready/tdata/tlast/tuser  packet byte, count, status
//
// A post or a flush gives one result transfer from the back sequencer; an emit
// gives 1 + sum over stored messages of (1 + length) packet bytes, up to 33 at
// the default size, through the single output byte register. The front takes a
// transfer a cycle while the two-entry command queue has room. Reset clears
// the count, the packet time and the queue; the message store is not cleared.
`default_nettype none

module ble_midi_packet_assembler import bmpa_pkg::*; #(
	parameter int MAX_MESSAGES = DEF_MAX_MESSAGES,
	parameter int MSG_BYTES    = DEF_MSG_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // msg_length, msg_byte0, msg_byte1, msg_byte2, post_time
	input  wire logic [1:0]  s_tuser,  // action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // out_byte, message_count
	output logic             m_tlast,  // last_byte
	output logic [1:0]       m_tuser   // status
);

`include "assert_macros.svh"

	queue_stat_t q_stat;
	logic        push, pop, cmd_valid;
	cmd_t        push_cmd, cmd;

	bmpa_front #(.MSG_BYTES(MSG_BYTES)) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	bmpa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.pop_valid (cmd_valid),
		.pop_cmd   (cmd),
		.q_stat    (q_stat)
	);

	bmpa_back #(.MAX_MESSAGES(MAX_MESSAGES), .MSG_BYTES(MSG_BYTES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	// The front never writes into a full queue.
	`ASSERT_SAME(a_no_push_full, push, !q_stat.full)
	// A dropped post is reported only with a full store.
	`ASSERT_SAME(a_drop_full, m_tvalid && m_tuser == ST_DROPPED,
		m_tdata[11:8] == CNT_W'(MAX_MESSAGES) && m_tlast)
	// A flush result closes its item and reports an empty store.
	`ASSERT_SAME(a_flush_empty, m_tvalid && m_tuser == ST_FLUSHED,
		m_tdata[11:8] == '0 && m_tlast && m_tdata[7:0] == '0)
	// A push into an empty queue makes a command available to the back.
	`ASSERT_NEXT(a_pop_after_push, push && q_stat.empty, cmd_valid)

endmodule

`default_nettype wire

/* rtl/core/bmpa_front.sv */
`default_nettype none

module bmpa_front import bmpa_pkg::*; #(
	parameter int MSG_BYTES = DEF_MSG_BYTES
) (
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // msg_length, msg_byte0, msg_byte1, msg_byte2, post_time
	input  wire logic [1:0]  s_tuser,  // action
	input  wire queue_stat_t q_stat,
	output logic             push,
	output cmd_t             push_cmd
);

	logic [LEN_W-1:0] raw_len;
	logic             known;

	// The front takes a transfer whenever the queue has room.
	assign s_tready = !q_stat.full;
	assign raw_len  = s_tdata[1:0];

	// Decode the action and saturate the message length.
	always_comb begin
		known         = 1'b1;
		push_cmd.kind = CMD_POST;
		case (s_tuser)
			ACT_POST:  push_cmd.kind = CMD_POST;
			ACT_EMIT:  push_cmd.kind = CMD_EMIT;
			ACT_FLUSH: push_cmd.kind = CMD_FLUSH;
			default:   known = 1'b0;
		endcase
		push_cmd.len = (raw_len > LEN_W'(MSG_BYTES)) ? LEN_W'(MSG_BYTES) : raw_len;
		push_cmd.msg_bytes[0] = s_tdata[9:2];
		push_cmd.msg_bytes[1] = s_tdata[17:10];
		push_cmd.msg_bytes[2] = s_tdata[25:18];
		push_cmd.post_time    = s_tdata[38:26];
	end

	// The unused action code is accepted and dropped here.
	assign push = s_tvalid && s_tready && known;

endmodule

`default_nettype wire

/* rtl/core/bmpa_queue.sv */
`default_nettype none

module bmpa_queue import bmpa_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output logic      pop_valid,
	output cmd_t      pop_cmd,
	output queue_stat_t q_stat
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	logic              do_pop;

	assign q_stat.full  = (fill_q == QCNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (fill_q == '0);
	assign pop_valid    = !q_stat.empty;
	assign pop_cmd      = slot_q[rd_ptr_q];
	assign do_pop       = pop && pop_valid;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !do_pop) fill_q <= fill_q + 1'b1;
			else if (!push && do_pop) fill_q <= fill_q - 1'b1;
		end
	end

	// Slot storage.
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_cmd;
	end

endmodule

`default_nettype wire

/* rtl/core/bmpa_back.sv */
`default_nettype none

module bmpa_back import bmpa_pkg::*; #(
	parameter int MAX_MESSAGES = DEF_MAX_MESSAGES,
	parameter int MSG_BYTES    = DEF_MSG_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	input  wire cmd_t        cmd,
	output logic             pop,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // out_byte, message_count
	output logic             m_tlast,  // last_byte
	output logic [1:0]       m_tuser   // status
);

	localparam int IDX_W = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1;
	localparam int BI_W  = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;

	// Message store, no reset: only entries below the count are read.
	logic [TLOW_W-1:0] time_mem [MAX_MESSAGES];
	logic [LEN_W-1:0]  len_mem  [MAX_MESSAGES];
	logic [BYTE_W-1:0] byte_mem [MAX_MESSAGES][MSG_BYTES];

	bk_state_t         state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic [TIME_W-1:0] packet_time_q;
	logic [IDX_W-1:0]  msg_idx_q;
	logic [LEN_W-1:0]  byte_idx_q;

	logic              valid_q;
	logic [BYTE_W-1:0] byte_q, byte_d;
	logic              last_q, last_d;
	logic [1:0]        status_q, status_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;

	logic              out_free, load, do_post, do_flush, start_emit;
	logic              step_msg, step_byte;
	logic              final_msg, msg_end;
	logic [LEN_W-1:0]  cur_len, sel;

	assign out_free  = !valid_q || m_tready;
	assign cur_len   = len_mem[msg_idx_q];
	assign sel       = byte_idx_q - 1'b1;
	assign final_msg = ((CNT_W'(msg_idx_q) + 1'b1) == count_q);
	assign msg_end   = (byte_idx_q == cur_len);

	// Sequencer: one command or packet byte per cycle when output is free.
	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		load       = 1'b0;
		do_post    = 1'b0;
		do_flush   = 1'b0;
		start_emit = 1'b0;
		step_msg   = 1'b0;
		step_byte  = 1'b0;
		byte_d     = '0;
		last_d     = 1'b1;
		status_d   = ST_PACKET;
		cnt_d      = count_q;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid && out_free) begin
					pop = 1'b1;
					case (cmd.kind)
						CMD_POST: begin
							load = 1'b1;
							if (count_q >= CNT_W'(MAX_MESSAGES)) begin
								status_d = ST_DROPPED;
							end else begin
								do_post  = 1'b1;
								status_d = ST_POSTED;
								cnt_d    = count_q + 1'b1;
							end
						end
						CMD_EMIT: begin
							load   = 1'b1;
							byte_d = {2'b10, packet_time_q[TIME_W-1:TLOW_W]};
							last_d = (count_q == '0);
							if (count_q != '0) begin
								start_emit = 1'b1;
								state_d    = BK_EMIT;
							end
						end
						CMD_FLUSH: begin
							load     = 1'b1;
							do_flush = 1'b1;
							status_d = ST_FLUSHED;
							cnt_d    = '0;
						end
						default: load = 1'b0;
					endcase
				end
			end
			BK_EMIT: begin
				if (out_free) begin
					load = 1'b1;
					if (byte_idx_q == '0) begin
						byte_d = {1'b1, time_mem[msg_idx_q]};
					end else begin
						byte_d = byte_mem[msg_idx_q][sel[BI_W-1:0]];
					end
					last_d = final_msg && msg_end;
					if (msg_end) begin
						if (final_msg) state_d = BK_IDLE;
						else step_msg = 1'b1;
					end else begin
						step_byte = 1'b1;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= BK_IDLE;
			count_q       <= '0;
			packet_time_q <= '0;
			msg_idx_q     <= '0;
			byte_idx_q    <= '0;
			valid_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_post) begin
				count_q <= count_q + 1'b1;
				if (count_q == '0) packet_time_q <= cmd.post_time;
			end else if (do_flush) begin
				count_q <= '0;
			end
			if (start_emit) begin
				msg_idx_q  <= '0;
				byte_idx_q <= '0;
			end else if (step_msg) begin
				msg_idx_q  <= msg_idx_q + 1'b1;
				byte_idx_q <= '0;
			end else if (step_byte) begin
				byte_idx_q <= byte_idx_q + 1'b1;
			end
			if (load) valid_q <= 1'b1;
			else if (m_tready) valid_q <= 1'b0;
		end
	end

	// Store writes and the output payload register.
	always_ff @(posedge clk) begin
		if (do_post) begin
			time_mem[count_q[IDX_W-1:0]] <= cmd.post_time[TLOW_W-1:0];
			len_mem[count_q[IDX_W-1:0]]  <= cmd.len;
			for (int k = 0; k < MSG_BYTES; k++) begin
				byte_mem[count_q[IDX_W-1:0]][k] <= cmd.msg_bytes[k];
			end
		end
		if (load) begin
			byte_q   <= byte_d;
			last_q   <= last_d;
			status_q <= status_d;
			cnt_q    <= cnt_d;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {4'd0, cnt_q, byte_q};
	assign m_tlast  = last_q;
	assign m_tuser  = status_q;

endmodule

`default_nettype wire

/* dv/ble_midi_packet_assembler_test.sv */
`default_nettype none

module ble_midi_packet_assembler_test import bmpa_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_MSGS = DEF_MAX_MESSAGES;
	localparam int MAX_BYTES = DEF_MSG_BYTES;
	localparam int RANDOM_ITEMS = 320;
	localparam int QUIET_ITEMS = 60;
	localparam int DRAIN_CYCLES = 50;
	localparam int CYCLE_LIMIT = 400000;

	// The one action code that the block ignores.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// One command on the slave side.
	typedef struct packed {
		logic [1:0]        action;
		logic [LEN_W-1:0]  len;
		logic [BYTE_W-1:0] b0;
		logic [BYTE_W-1:0] b1;
		logic [BYTE_W-1:0] b2;
		logic [TIME_W-1:0] post_time;
	} midi_cmd_t;

	// One entry of the message store as the predictor keeps it.
	typedef struct packed {
		logic [TLOW_W-1:0]                  time_low;
		logic [LEN_W-1:0]                   len;
		logic [FIELD_BYTES-1:0][BYTE_W-1:0] bytes;
	} held_msg_t;

	// One transfer on the master side.
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last;
		logic [1:0]        status;
		logic [CNT_W-1:0]  count;
	} midi_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;

	// Predictor state.
	held_msg_t         held_msgs [MAX_MSGS];
	logic [CNT_W-1:0]  held_count;
	logic [TIME_W-1:0] held_packet_time;
	midi_result_t      results_due [$];

	int  error_count;
	int  cycle_count;
	logic quiet;

	ble_midi_packet_assembler DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Queue one expected transfer with the current message count.
	function automatic void push_result(input logic [BYTE_W-1:0] b, input logic last,
			input logic [1:0] status);
		midi_result_t r;
		r.out_byte = b;
		r.last = last;
		r.status = status;
		r.count = held_count;
		results_due.push_back(r);
	endfunction

	// Advance the predicted store by one accepted command and queue its results.
	function automatic void apply_action(input midi_cmd_t c);
		held_msg_t m;
		logic [LEN_W-1:0] n;
		logic final_msg;
		case (c.action)
			ACT_POST: begin
				if (held_count >= MAX_MSGS) begin
					push_result(8'h00, 1'b1, ST_DROPPED);
				end else begin
					n = (c.len > MAX_BYTES) ? LEN_W'(MAX_BYTES) : c.len;
					if (held_count == 0)
						held_packet_time = c.post_time;
					m.time_low = c.post_time[TLOW_W-1:0];
					m.len = n;
					m.bytes = '0;
					if (n > 0) m.bytes[0] = c.b0;
					if (n > 1) m.bytes[1] = c.b1;
					if (n > 2) m.bytes[2] = c.b2;
					held_msgs[int'(held_count)] = m;
					held_count = held_count + 1'b1;
					push_result(8'h00, 1'b1, ST_POSTED);
				end
			end
			ACT_EMIT: begin
				push_result({2'b10, held_packet_time[TIME_W-1:TLOW_W]},
					held_count == 0, ST_PACKET);
				for (int i = 0; i < int'(held_count); i++) begin
					m = held_msgs[i];
					final_msg = (i + 1 == int'(held_count));
					push_result({1'b1, m.time_low}, final_msg && m.len == 0, ST_PACKET);
					for (int j = 0; j < int'(m.len); j++)
						push_result(m.bytes[j], final_msg && (j + 1 == int'(m.len)),
							ST_PACKET);
				end
			end
			ACT_FLUSH: begin
				held_count = '0;
				push_result(8'h00, 1'b1, ST_FLUSHED);
			end
			default: begin
				// Unused code: nothing happens.
			end
		endcase
	endfunction

	// A command of the given action with every other field drawn at random.
	function automatic midi_cmd_t random_message(input logic [1:0] action);
		midi_cmd_t c;
		c.action = action;
		c.len = LEN_W'($urandom_range(3));
		c.b0 = BYTE_W'($urandom);
		c.b1 = BYTE_W'($urandom);
		c.b2 = BYTE_W'($urandom);
		c.post_time = TIME_W'($urandom);
		return c;
	endfunction

	function automatic midi_cmd_t make_cmd(input logic [1:0] action, input logic [1:0] len,
			input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
			input logic [12:0] t);
		midi_cmd_t c;
		c.action = action;
		c.len = len;
		c.b0 = b0;
		c.b1 = b1;
		c.b2 = b2;
		c.post_time = t;
		return c;
	endfunction

	// Drive one command, wait for its transfer and update the predictor.
	task automatic send_item(input midi_cmd_t c);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 35) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, c.post_time, c.b2, c.b1, c.b0, c.len};
		s_tuser <= c.action;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		apply_action(c);
	endtask

	// Emit and flush on an empty store, and the ignored action code.
	task automatic test_empty_store();
		send_item(make_cmd(ACT_EMIT, 2'd0, 8'h00, 8'h00, 8'h00, 13'h0000));
		send_item(make_cmd(ACT_FLUSH, 2'd3, 8'hFF, 8'hFF, 8'hFF, 13'h1FFF));
		send_item(random_message(ACT_UNUSED));
		send_item(make_cmd(ACT_EMIT, 2'd3, 8'hFF, 8'hFF, 8'hFF, 13'h1FFF));
	endtask

	// Every message length, extreme bytes and times, then one packet.
	task automatic test_lengths();
		send_item(make_cmd(ACT_POST, 2'd0, 8'hFF, 8'hFF, 8'hFF, 13'h1FFF));
		send_item(make_cmd(ACT_POST, 2'd1, 8'h90, 8'hFF, 8'hFF, 13'h0000));
		send_item(make_cmd(ACT_POST, 2'd2, 8'hFF, 8'h7F, 8'h00, 13'h0AAA));
		send_item(make_cmd(ACT_POST, 2'd3, 8'h80, 8'h00, 8'hFF, 13'h1555));
		send_item(make_cmd(ACT_EMIT, 2'd0, 8'h00, 8'h00, 8'h00, 13'h0000));
	endtask

	// Fill the store with full-size messages, overflow it, emit the longest packet, then flush and emit an empty one.
	task automatic test_full_store();
		send_item(make_cmd(ACT_FLUSH, 2'd0, 8'h00, 8'h00, 8'h00, 13'h0000));
		for (int i = 0; i < MAX_MSGS; i++)
			send_item(make_cmd(ACT_POST, 2'd3, (i % 2) ? 8'hAA : 8'h55,
				(i % 2) ? 8'h55 : 8'hAA, 8'(i), 13'(i * 1170)));
		send_item(make_cmd(ACT_POST, 2'd3, 8'hC0, 8'h01, 8'h02, 13'h1000));
		send_item(make_cmd(ACT_EMIT, 2'd0, 8'h00, 8'h00, 8'h00, 13'h0000));
		send_item(make_cmd(ACT_FLUSH, 2'd0, 8'h00, 8'h00, 8'h00, 13'h0000));
		send_item(make_cmd(ACT_EMIT, 2'd0, 8'h00, 8'h00, 8'h00, 13'h0000));
	endtask

	// Bursts of posts closed by an emit and often a flush, with stray commands mixed in.
	task automatic test_random_traffic();
		int sent;
		int burst;
		midi_cmd_t c;
		sent = 0;
		quiet = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			if (sent >= QUIET_ITEMS)
				quiet = 1'b0;
			if ($urandom_range(9) == 0) begin
				c = random_message(2'($urandom_range(3)));
				send_item(c);
				if (c.action != ACT_UNUSED)
					sent++;
			end else begin
				burst = $urandom_range(9);
				for (int k = 0; k < burst; k++) begin
					send_item(random_message(ACT_POST));
					sent++;
				end
				send_item(random_message(ACT_EMIT));
				sent++;
				if ($urandom_range(2) != 0) begin
					send_item(random_message(ACT_FLUSH));
					sent++;
				end
			end
		end
		quiet = 1'b0;
	endtask

	// Receiver backpressure, changed at the falling edge.
	always @(negedge clk)
		m_tready <= quiet || ($urandom_range(99) >= 35);

	// Compare each master transfer with the oldest expected one.
	always @(posedge clk) begin
		midi_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				$display("%0t: unexpected transfer byte %02h last %0d status %0d count %0d",
					$realtime, m_tdata[7:0], m_tlast, m_tuser, m_tdata[11:8]);
				error_count++;
			end else begin
				want = results_due.pop_front();
				if (m_tdata[7:0] !== want.out_byte || m_tlast !== want.last ||
						m_tuser !== want.status || m_tdata[11:8] !== want.count ||
						m_tdata[15:12] !== 4'h0) begin
					$display("%0t: mismatch expected byte %02h last %0d status %0d count %0d",
						$realtime, want.out_byte, want.last, want.status, want.count);
					$display("%0t:          actual   byte %02h last %0d status %0d count %0d pad %0h",
						$realtime, m_tdata[7:0], m_tlast, m_tuser, m_tdata[11:8],
						m_tdata[15:12]);
					error_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		quiet = 1'b0;
		error_count = 0;
		cycle_count = 0;
		held_count = '0;
		held_packet_time = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_store();
		test_lengths();
		test_full_store();
		test_random_traffic();

		// Let the last packet drain before judging the run.
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* ble_midi_packet_assembler.f */
+incdir+rtl/core
rtl/core/bmpa_pkg.sv
rtl/core/bmpa_front.sv
rtl/core/bmpa_queue.sv
rtl/core/bmpa_back.sv
rtl/core/ble_midi_packet_assembler.sv
dv/ble_midi_packet_assembler_test.sv
